// ===== rtl/rdlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Row DMA load controller package
// Shared types, sizes and helpers for the strided row move-in DMA.
// ----------------------------------------------------------------------------
package rdlc_pkg;

    localparam int NUM_BUFFERS = 8;
    localparam int NUM_CREDITS = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int ID_BITS     = 8;

    localparam int BUF_IW  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int BUF_CW  = $clog2(NUM_BUFFERS + 1);
    localparam int CRD_IW  = (NUM_CREDITS > 1) ? $clog2(NUM_CREDITS) : 1;
    localparam int CRD_CW  = $clog2(NUM_CREDITS + 1);
    localparam int Q_IW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_N    = 1 << ID_BITS;

    localparam int ADDR_W  = 40;
    localparam int STR_W   = 32;
    localparam int SPAD_W  = 32;
    localparam int ROW_W   = 11;
    localparam int IDF_W   = 8;
    localparam int BUFF_W  = 3;
    localparam int CRDF_W  = 2;

    typedef enum logic [1:0] {
        OP_ISSUE    = 2'd0,
        OP_DRAM_RSP = 2'd1,
        OP_SPAD_RSP = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                op;
        logic [IDF_W-1:0]   cmd_id;
        logic [ADDR_W-1:0]  src;
        logic [STR_W-1:0]   sstride;
        logic [SPAD_W-1:0]  dst;
        logic [STR_W-1:0]   dstride;
        logic [ROW_W-1:0]   rows;
        logic [BUFF_W-1:0]  buf_idx;
        logic [CRDF_W-1:0]  crd_idx;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  address;
        logic [BUFF_W-1:0]  buffer_slot;
        logic [CRDF_W-1:0]  credit_slot;
        logic [IDF_W-1:0]   result_instr;
        logic [ROW_W-1:0]   row_number;
        logic               queue_has_room;
        logic               issue_rejected;
        logic               last;
    } t_result;

    function automatic int unsigned ring_idx(int unsigned h, int unsigned c, int unsigned n);
        int unsigned s;
        s = h + c;
        return (s >= n) ? s - n : s;
    endfunction

    function automatic t_result make_result(t_kind kind, logic [ADDR_W-1:0] address,
                                            logic [BUFF_W-1:0] buffer_slot,
                                            logic [CRDF_W-1:0] credit_slot,
                                            logic [IDF_W-1:0] result_instr,
                                            logic [ROW_W-1:0] row_number,
                                            logic room, logic rej, logic last);
        t_result r;
        r.kind           = kind;
        r.address        = address;
        r.buffer_slot    = buffer_slot;
        r.credit_slot    = credit_slot;
        r.result_instr   = result_instr;
        r.row_number     = row_number;
        r.queue_has_room = room;
        r.issue_rejected = rej;
        r.last           = last;
        return r;
    endfunction

endpackage

// ===== rtl/row_dma_load_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Row DMA load controller
// Strided move-in DMA: splits instructions into row reads and row writes.
// ----------------------------------------------------------------------------
// Items are executed one at a time by the execute sequencer: the next item is
// taken from the front queue only after the current one has emitted its status
// item, which closes every item. An item may also emit row reads and row writes
// for work in flight; output stalls hold the sequencer.
// Reset: synchronous, active low; lists, queue, counters and row-count valid
// bits clear together, no clearing pass.
module row_dma_load_controller_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // cmd_id, dram_source, src_pitch, spad_destination, dst_pitch,
    // row_count, buffer_index, credit_index
    input  logic [159:0]  s_axis_tdata,
    // operation
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // address, buffer_slot, credit_slot, result_instr, row_number,
    // queue_has_room, issue_rejected, zero fill
    output logic [71:0]   m_axis_tdata,
    // kind
    output logic [1:0]    m_axis_tuser,
    output logic          m_axis_tlast
);

    rdlc_pkg::t_cmd    w_cmd;
    rdlc_pkg::t_result w_res;
    logic              w_cmd_valid;
    logic              w_pop;

    rdlc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_pop         (w_pop),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd)
    );

    rdlc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.issue_rejected, w_res.queue_has_room,
                           w_res.row_number, w_res.result_instr, w_res.credit_slot,
                           w_res.buffer_slot, w_res.address};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

endmodule

// ===== rtl/rdlc_front.sv =====
// ----------------------------------------------------------------------------
// Row DMA front end
// Accept input items, decode the operation and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module rdlc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [159:0]        s_axis_tdata,
    input  logic [1:0]          s_axis_tuser,
    input  logic                i_pop,
    output logic                o_cmd_valid,
    output rdlc_pkg::t_cmd      o_cmd
);

    rdlc_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    rdlc_pkg::t_cmd w_dec;
    logic           w_push;

    always_comb begin
        w_dec.op       = rdlc_pkg::t_op'(s_axis_tuser);
        w_dec.cmd_id   = s_axis_tdata[7:0];
        w_dec.src      = s_axis_tdata[47:8];
        w_dec.sstride  = s_axis_tdata[79:48];
        w_dec.dst      = s_axis_tdata[111:80];
        w_dec.dstride  = s_axis_tdata[143:112];
        w_dec.rows     = s_axis_tdata[154:144];
        w_dec.buf_idx  = s_axis_tdata[157:155];
        w_dec.crd_idx  = s_axis_tdata[159:158];
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_cnt != 2'd0);
    assign o_cmd         = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_dec;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/rdlc_engine.sv =====
// ----------------------------------------------------------------------------
// Row DMA back end
// Execute decoded items: instruction queue, row splitting, buffer and credit
// lists, row counters and the result register.
// ----------------------------------------------------------------------------
module rdlc_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  rdlc_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output rdlc_pkg::t_result   o_res
);

    localparam int NB  = rdlc_pkg::NUM_BUFFERS;
    localparam int NC  = rdlc_pkg::NUM_CREDITS;
    localparam int QD  = rdlc_pkg::QUEUE_DEPTH;
    localparam int BIW = rdlc_pkg::BUF_IW;
    localparam int BCW = rdlc_pkg::BUF_CW;
    localparam int CIW = rdlc_pkg::CRD_IW;
    localparam int CCW = rdlc_pkg::CRD_CW;
    localparam int QIW = rdlc_pkg::Q_IW;
    localparam int QCW = rdlc_pkg::Q_CW;
    localparam int IB  = rdlc_pkg::ID_BITS;
    localparam int RW  = rdlc_pkg::ROW_W;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_RLRD, S_RLUPD, S_RDCHK, S_RDMUL, S_RDEMIT,
        S_WRCHK, S_WREMIT, S_STAT
    } t_state;

    typedef enum logic [1:0] {
        B_FREE, B_READING, B_READY, B_WRITING
    } t_buf_state;

    typedef struct packed {
        logic [IB-1:0]                   id;
        logic [rdlc_pkg::ADDR_W-1:0]     src;
        logic [rdlc_pkg::STR_W-1:0]      sstride;
        logic [rdlc_pkg::SPAD_W-1:0]     dst;
        logic [rdlc_pkg::STR_W-1:0]      dstride;
        logic [RW-1:0]                   rows;
    } t_qent;

    typedef struct packed {
        logic [IB-1:0]                   id;
        logic [RW-1:0]                   row;
        logic [rdlc_pkg::SPAD_W-1:0]     spad;
    } t_tag;

    t_state             r_state;
    rdlc_pkg::t_cmd     r_cmd;
    logic               r_rej;

    t_qent              r_q [QD];
    logic [QIW-1:0]     r_qhead;
    logic [QCW-1:0]     r_qfill;

    logic               r_act;
    t_qent              r_act_e;
    logic [RW-1:0]      r_row;
    logic [rdlc_pkg::ADDR_W-1:0] r_psrc;
    logic [rdlc_pkg::SPAD_W-1:0] r_pdst;

    logic [BIW-1:0]     r_flist [NB];
    logic [BIW-1:0]     r_fhead;
    logic [BCW-1:0]     r_fcnt;
    logic [BIW-1:0]     r_rlist [NB];
    logic [BIW-1:0]     r_rhead;
    logic [BCW-1:0]     r_rcnt;
    logic [CIW-1:0]     r_clist [NC];
    logic [CIW-1:0]     r_chead;
    logic [CCW-1:0]     r_ccnt;
    t_buf_state         r_bstate [NB];
    logic               r_cbusy [NC];
    logic [BIW-1:0]     r_cbuf [NC];
    t_tag               r_tag [NB];

    logic [RW-1:0]      r_rl_mem [rdlc_pkg::ID_N];
    logic               r_rl_vld [rdlc_pkg::ID_N];
    logic [RW-1:0]      r_rl_q;
    logic [IB-1:0]      r_done_id;

    logic               r_out_valid;
    rdlc_pkg::t_result  r_out;

    logic               w_out_ok;
    logic               w_emit;
    logic [IB-1:0]      w_iid;
    logic [BIW-1:0]     w_rb;
    logic [CIW-1:0]     w_rc;
    logic               w_b_ok;
    logic               w_c_ok;
    logic [BIW-1:0]     w_tag_idx;
    t_tag               w_tag;
    logic [QIW-1:0]     w_qtail;
    logic [BIW-1:0]     w_ftail;
    logic [BIW-1:0]     w_rtail;
    logic [CIW-1:0]     w_ctail;
    logic [RW-1:0]      w_rl_cur;
    logic               w_rl_we;
    logic [IB-1:0]      w_rl_wa;
    logic [RW-1:0]      w_rl_wd;
    logic [BIW-1:0]     w_fb;
    logic [BIW-1:0]     w_wb;
    logic [CIW-1:0]     w_wc;

    assign w_out_ok  = !r_out_valid || i_res_ready;
    assign w_iid     = r_cmd.cmd_id[IB-1:0];
    assign w_rb      = BIW'(r_cmd.buf_idx);
    assign w_rc      = CIW'(r_cmd.crd_idx);
    assign w_b_ok    = (int'(r_cmd.buf_idx) < NB) && (r_bstate[w_rb] == B_READING);
    assign w_c_ok    = (int'(r_cmd.crd_idx) < NC) && r_cbusy[w_rc];
    assign w_tag_idx = (r_state == S_EXEC) ? r_cbuf[w_rc] : r_rlist[r_rhead];
    assign w_tag     = r_tag[w_tag_idx];
    assign w_qtail   = QIW'(rdlc_pkg::ring_idx(r_qhead, r_qfill, QD));
    assign w_ftail   = BIW'(rdlc_pkg::ring_idx(r_fhead, r_fcnt, NB));
    assign w_rtail   = BIW'(rdlc_pkg::ring_idx(r_rhead, r_rcnt, NB));
    assign w_ctail   = CIW'(rdlc_pkg::ring_idx(r_chead, r_ccnt, NC));
    assign w_rl_cur  = r_rl_vld[r_done_id] ? r_rl_q : '0;
    assign w_fb      = r_flist[r_fhead];
    assign w_wb      = r_rlist[r_rhead];
    assign w_wc      = r_clist[r_chead];
    assign o_pop     = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid = r_out_valid;
    assign o_res     = r_out;

    assign w_emit = w_out_ok && (
        (r_state == S_EXEC && r_cmd.op == rdlc_pkg::OP_ISSUE && int'(r_qfill) < QD
         && r_cmd.rows == '0)
        || (r_state == S_RLUPD && w_rl_cur == RW'(1))
        || r_state == S_RDEMIT || r_state == S_WREMIT || r_state == S_STAT);

    always_comb begin
        w_rl_we = 1'b0;
        w_rl_wa = w_iid;
        w_rl_wd = r_cmd.rows;
        if (r_state == S_EXEC && w_out_ok && r_cmd.op == rdlc_pkg::OP_ISSUE
            && int'(r_qfill) < QD) begin
            w_rl_we = 1'b1;
        end else if (r_state == S_RLUPD && w_out_ok && w_rl_cur != '0) begin
            w_rl_we = 1'b1;
            w_rl_wa = r_done_id;
            w_rl_wd = w_rl_cur - RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rl_we) begin
            r_rl_mem[w_rl_wa] <= w_rl_wd;
        end
        r_rl_q <= r_rl_mem[r_done_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qhead     <= '0;
            r_qfill     <= '0;
            r_act       <= 1'b0;
            r_row       <= '0;
            r_fhead     <= '0;
            r_fcnt      <= BCW'(NB);
            r_rhead     <= '0;
            r_rcnt      <= '0;
            r_chead     <= '0;
            r_ccnt      <= CCW'(NC);
            r_out_valid <= 1'b0;
            for (int i = 0; i < NB; i++) begin
                r_flist[i]  <= BIW'(i);
                r_bstate[i] <= B_FREE;
            end
            for (int i = 0; i < NC; i++) begin
                r_clist[i] <= CIW'(i);
                r_cbusy[i] <= 1'b0;
            end
            for (int i = 0; i < rdlc_pkg::ID_N; i++) begin
                r_rl_vld[i] <= 1'b0;
            end
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_rl_we) begin
                r_rl_vld[w_rl_wa] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_rej   <= 1'b0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_ok) begin
                        case (r_cmd.op)
                            rdlc_pkg::OP_ISSUE: begin
                                r_state <= S_RDCHK;
                                if (int'(r_qfill) >= QD) begin
                                    r_rej <= 1'b1;
                                end else if (r_cmd.rows == '0) begin
                                    r_out <= rdlc_pkg::make_result(rdlc_pkg::KIND_DONE,
                                        '0, '0, '0, rdlc_pkg::IDF_W'(w_iid), '0,
                                        1'b0, 1'b0, 1'b0);
                                end else begin
                                    r_q[w_qtail] <= '{id: w_iid, src: r_cmd.src,
                                        sstride: r_cmd.sstride, dst: r_cmd.dst,
                                        dstride: r_cmd.dstride, rows: r_cmd.rows};
                                    r_qfill <= r_qfill + QCW'(1);
                                end
                            end
                            rdlc_pkg::OP_DRAM_RSP: begin
                                r_state <= S_RDCHK;
                                if (w_b_ok) begin
                                    r_bstate[w_rb]   <= B_READY;
                                    r_rlist[w_rtail] <= w_rb;
                                    r_rcnt           <= r_rcnt + BCW'(1);
                                end
                            end
                            rdlc_pkg::OP_SPAD_RSP: begin
                                if (w_c_ok) begin
                                    r_cbusy[w_rc]          <= 1'b0;
                                    r_clist[w_ctail]       <= w_rc;
                                    r_ccnt                 <= r_ccnt + CCW'(1);
                                    r_bstate[w_tag_idx]    <= B_FREE;
                                    r_flist[w_ftail]       <= w_tag_idx;
                                    r_fcnt                 <= r_fcnt + BCW'(1);
                                    r_done_id              <= w_tag.id;
                                    r_state                <= S_RLRD;
                                end else begin
                                    r_state <= S_RDCHK;
                                end
                            end
                            default: begin
                                r_state <= S_RDCHK;
                            end
                        endcase
                    end
                end
                S_RLRD: begin
                    r_state <= S_RLUPD;
                end
                S_RLUPD: begin
                    if (w_out_ok) begin
                        if (w_rl_cur == RW'(1)) begin
                            r_out <= rdlc_pkg::make_result(rdlc_pkg::KIND_DONE,
                                '0, '0, '0, rdlc_pkg::IDF_W'(r_done_id), '0,
                                1'b0, 1'b0, 1'b0);
                        end
                        r_state <= S_RDCHK;
                    end
                end
                S_RDCHK: begin
                    if (!r_act && r_qfill != '0) begin
                        r_act_e <= r_q[r_qhead];
                        r_act   <= (r_q[r_qhead].rows != '0);
                        r_row   <= '0;
                        r_qhead <= QIW'(rdlc_pkg::ring_idx(r_qhead, 1, QD));
                        r_qfill <= r_qfill - QCW'(1);
                    end else if (r_act && r_fcnt != '0) begin
                        r_state <= S_RDMUL;
                    end else begin
                        r_state <= S_WRCHK;
                    end
                end
                S_RDMUL: begin
                    r_psrc  <= r_row * rdlc_pkg::ADDR_W'(r_act_e.sstride);
                    r_pdst  <= rdlc_pkg::SPAD_W'(r_row) * r_act_e.dstride;
                    r_state <= S_RDEMIT;
                end
                S_RDEMIT: begin
                    if (w_out_ok) begin
                        r_fhead        <= BIW'(rdlc_pkg::ring_idx(r_fhead, 1, NB));
                        r_fcnt         <= r_fcnt - BCW'(1);
                        r_bstate[w_fb] <= B_READING;
                        r_tag[w_fb]    <= '{id: r_act_e.id, row: r_row,
                                            spad: r_act_e.dst + r_pdst};
                        r_out <= rdlc_pkg::make_result(rdlc_pkg::KIND_READ,
                            r_act_e.src + r_psrc, rdlc_pkg::BUFF_W'(w_fb), '0,
                            rdlc_pkg::IDF_W'(r_act_e.id), r_row, 1'b0, 1'b0, 1'b0);
                        if ((r_row + RW'(1)) >= r_act_e.rows || r_row == '1) begin
                            r_act <= 1'b0;
                            r_row <= '0;
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                        r_state <= S_RDCHK;
                    end
                end
                S_WRCHK: begin
                    if (r_rcnt != '0 && r_ccnt != '0) begin
                        r_state <= S_WREMIT;
                    end else begin
                        r_state <= S_STAT;
                    end
                end
                S_WREMIT: begin
                    if (w_out_ok) begin
                        r_rhead        <= BIW'(rdlc_pkg::ring_idx(r_rhead, 1, NB));
                        r_rcnt         <= r_rcnt - BCW'(1);
                        r_chead        <= CIW'(rdlc_pkg::ring_idx(r_chead, 1, NC));
                        r_ccnt         <= r_ccnt - CCW'(1);
                        r_bstate[w_wb] <= B_WRITING;
                        r_cbusy[w_wc]  <= 1'b1;
                        r_cbuf[w_wc]   <= w_wb;
                        r_out <= rdlc_pkg::make_result(rdlc_pkg::KIND_WRITE,
                            rdlc_pkg::ADDR_W'(w_tag.spad), rdlc_pkg::BUFF_W'(w_wb),
                            rdlc_pkg::CRDF_W'(w_wc), rdlc_pkg::IDF_W'(w_tag.id),
                            w_tag.row, 1'b0, 1'b0, 1'b0);
                        r_state <= S_WRCHK;
                    end
                end
                S_STAT: begin
                    if (w_out_ok) begin
                        r_out <= rdlc_pkg::make_result(rdlc_pkg::KIND_STATUS,
                            '0, '0, '0, '0, '0, (int'(r_qfill) < QD), r_rej, 1'b1);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rdlc_checker.sv =====
// ----------------------------------------------------------------------------
// Row DMA checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rdlc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [71:0]   m_axis_tdata,
    input logic [1:0]    m_axis_tuser,
    input logic          m_axis_tlast
);

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == rdlc_pkg::KIND_STATUS)))
        else $error("tlast does not match status kind");

    a_status_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == rdlc_pkg::KIND_STATUS)
        |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("status item carries request fields");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind row_dma_load_controller_unit rdlc_checker u_rdlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_row_dma_load_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Row DMA load controller testbench
// Builds a stream of issue and response items from a behavioral copy of the
// controller. The copy tracks the queue, buffers and credits. Well-formed
// responses are chosen from what is outstanding, mixed with stray and noise
// items. Every result is checked in order against the predicted stream, under
// bursty input and stalling output with one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_row_dma_load_controller_unit;

    typedef enum int {B_FREE, B_READING, B_READY, B_WRITING} t_bstate;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [159:0]  s_axis_tdata;
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [71:0]   m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          m_axis_tlast;

    row_dma_load_controller_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rdlc_pkg::t_cmd    pending_items[$];
    rdlc_pkg::t_result expected_results[$];
    int      errors = 0;
    int      items_in = 0;
    bit      stim_done = 0;

    // controller shadow state
    bit [7:0]  q_id[rdlc_pkg::QUEUE_DEPTH];
    bit [39:0] q_src[rdlc_pkg::QUEUE_DEPTH];
    bit [31:0] q_ss[rdlc_pkg::QUEUE_DEPTH], q_dst[rdlc_pkg::QUEUE_DEPTH];
    bit [31:0] q_ds[rdlc_pkg::QUEUE_DEPTH];
    bit [10:0] q_rows[rdlc_pkg::QUEUE_DEPTH];
    int        q_head, q_fill;
    bit        act_valid;
    bit [7:0]  act_id;
    bit [10:0] act_rows, cur_row;
    bit [39:0] act_src;
    bit [31:0] act_ss, act_dst, act_ds;
    int        fb_list[rdlc_pkg::NUM_BUFFERS], fb_head, fb_cnt;
    int        rb_list[rdlc_pkg::NUM_BUFFERS], rb_head, rb_cnt;
    int        fc_list[rdlc_pkg::NUM_CREDITS], fc_head, fc_cnt;
    t_bstate   buf_st[rdlc_pkg::NUM_BUFFERS];
    bit        crd_busy[rdlc_pkg::NUM_CREDITS];
    int        crd_buf[rdlc_pkg::NUM_CREDITS];
    bit [7:0]  tag_id[rdlc_pkg::NUM_BUFFERS];
    bit [10:0] tag_row[rdlc_pkg::NUM_BUFFERS];
    bit [31:0] tag_spad[rdlc_pkg::NUM_BUFFERS];
    bit [11:0] rows_left[rdlc_pkg::ID_N];

    function automatic void push_result(rdlc_pkg::t_kind k, bit [39:0] a, bit [2:0] b,
                                        bit [1:0] c, bit [7:0] id, bit [10:0] row,
                                        bit room, bit rej, bit lst);
        rdlc_pkg::t_result r;
        r.kind = k; r.address = a; r.buffer_slot = b; r.credit_slot = c;
        r.result_instr = id; r.row_number = row; r.queue_has_room = room;
        r.issue_rejected = rej; r.last = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void reset_shadow();
        q_head = 0; q_fill = 0; act_valid = 0; cur_row = 0;
        fb_head = 0; fb_cnt = rdlc_pkg::NUM_BUFFERS; rb_head = 0; rb_cnt = 0;
        fc_head = 0; fc_cnt = rdlc_pkg::NUM_CREDITS;
        for (int i = 0; i < rdlc_pkg::NUM_BUFFERS; i++) begin
            fb_list[i] = i; buf_st[i] = B_FREE;
        end
        for (int i = 0; i < rdlc_pkg::NUM_CREDITS; i++) begin
            fc_list[i] = i; crd_busy[i] = 0;
        end
        foreach (rows_left[i]) rows_left[i] = 0;
    endfunction

    // advance the shadow by one item and queue its results
    function automatic void move_rows(rdlc_pkg::t_cmd c);
        bit rej;
        int t, b, cr;
        longint unsigned r;
        rej = 0;
        case (c.op)
            rdlc_pkg::OP_ISSUE: begin
                if (q_fill >= rdlc_pkg::QUEUE_DEPTH) begin
                    rej = 1;
                end else begin
                    rows_left[c.cmd_id] = 12'(c.rows);
                    if (c.rows == 0) begin
                        push_result(rdlc_pkg::KIND_DONE, '0, '0, '0, c.cmd_id, '0, 0, 0, 0);
                    end else begin
                        t = (q_head + q_fill) % rdlc_pkg::QUEUE_DEPTH;
                        q_id[t] = c.cmd_id; q_src[t] = c.src; q_ss[t] = c.sstride;
                        q_dst[t] = c.dst; q_ds[t] = c.dstride; q_rows[t] = c.rows;
                        q_fill++;
                    end
                end
            end
            rdlc_pkg::OP_DRAM_RSP: begin
                b = c.buf_idx;
                if (buf_st[b] == B_READING) begin
                    buf_st[b] = B_READY;
                    rb_list[(rb_head + rb_cnt) % rdlc_pkg::NUM_BUFFERS] = b;
                    rb_cnt++;
                end
            end
            rdlc_pkg::OP_SPAD_RSP: begin
                cr = c.crd_idx;
                if (crd_busy[cr]) begin
                    b = crd_buf[cr];
                    crd_busy[cr] = 0;
                    fc_list[(fc_head + fc_cnt) % rdlc_pkg::NUM_CREDITS] = cr;
                    fc_cnt++;
                    buf_st[b] = B_FREE;
                    fb_list[(fb_head + fb_cnt) % rdlc_pkg::NUM_BUFFERS] = b;
                    fb_cnt++;
                    if (rows_left[tag_id[b]] != 0) begin
                        rows_left[tag_id[b]]--;
                        if (rows_left[tag_id[b]] == 0)
                            push_result(rdlc_pkg::KIND_DONE, '0, '0, '0, tag_id[b], '0,
                                        0, 0, 0);
                    end
                end
            end
            default: ;
        endcase
        forever begin
            if (!act_valid && q_fill > 0) begin
                act_id = q_id[q_head]; act_src = q_src[q_head]; act_ss = q_ss[q_head];
                act_dst = q_dst[q_head]; act_ds = q_ds[q_head]; act_rows = q_rows[q_head];
                act_valid = act_rows != 0;
                cur_row = 0;
                q_head = (q_head + 1) % rdlc_pkg::QUEUE_DEPTH;
                q_fill--;
                continue;
            end
            if (!act_valid || fb_cnt == 0) break;
            b = fb_list[fb_head];
            fb_head = (fb_head + 1) % rdlc_pkg::NUM_BUFFERS;
            fb_cnt--;
            r = cur_row;
            buf_st[b] = B_READING;
            tag_id[b] = act_id; tag_row[b] = cur_row;
            tag_spad[b] = 32'(act_dst + r * act_ds);
            push_result(rdlc_pkg::KIND_READ, 40'(act_src + r * act_ss), 3'(b), '0,
                        act_id, cur_row, 0, 0, 0);
            cur_row++;
            if (cur_row >= act_rows) begin
                act_valid = 0; cur_row = 0;
            end
        end
        while (rb_cnt > 0 && fc_cnt > 0) begin
            b = rb_list[rb_head]; cr = fc_list[fc_head];
            rb_head = (rb_head + 1) % rdlc_pkg::NUM_BUFFERS; rb_cnt--;
            fc_head = (fc_head + 1) % rdlc_pkg::NUM_CREDITS; fc_cnt--;
            buf_st[b] = B_WRITING; crd_busy[cr] = 1; crd_buf[cr] = b;
            push_result(rdlc_pkg::KIND_WRITE, {8'd0, tag_spad[b]}, 3'(b), 2'(cr),
                        tag_id[b], tag_row[b], 0, 0, 0);
        end
        push_result(rdlc_pkg::KIND_STATUS, '0, '0, '0, '0, '0,
                    q_fill < rdlc_pkg::QUEUE_DEPTH, rej, 1);
    endfunction

    function automatic rdlc_pkg::t_cmd rand_cmd();
        rdlc_pkg::t_cmd c;
        c.op = rdlc_pkg::t_op'(2'($urandom_range(0, 3)));
        c.cmd_id = 8'($urandom);
        c.src = 40'({$urandom, $urandom});
        c.sstride = $urandom; c.dst = $urandom; c.dstride = $urandom;
        c.rows = 11'($urandom);
        c.buf_idx = 3'($urandom); c.crd_idx = 2'($urandom);
        return c;
    endfunction

    function automatic void add_item(rdlc_pkg::t_cmd c);
        move_rows(c);
        pending_items.push_back(c);
    endfunction

    function automatic void add_issue(bit [7:0] id, bit [39:0] src, bit [31:0] ss,
                                      bit [31:0] dst, bit [31:0] ds, bit [10:0] rows);
        rdlc_pkg::t_cmd c;
        c = rand_cmd();
        c.op = rdlc_pkg::OP_ISSUE; c.cmd_id = id; c.src = src; c.sstride = ss;
        c.dst = dst; c.dstride = ds; c.rows = rows;
        add_item(c);
    endfunction

    // answer one outstanding read or write, picked at random; 0 if none
    function automatic bit add_response(bit prefer_read);
        int rd[$], wr[$];
        rdlc_pkg::t_cmd c;
        for (int i = 0; i < rdlc_pkg::NUM_BUFFERS; i++)
            if (buf_st[i] == B_READING) rd.push_back(i);
        for (int i = 0; i < rdlc_pkg::NUM_CREDITS; i++)
            if (crd_busy[i]) wr.push_back(i);
        if (rd.size() == 0 && wr.size() == 0) return 0;
        c = rand_cmd();
        if (rd.size() != 0 && (prefer_read || wr.size() == 0)) begin
            c.op = rdlc_pkg::OP_DRAM_RSP;
            c.buf_idx = 3'(rd[$urandom_range(0, rd.size() - 1)]);
        end else begin
            c.op = rdlc_pkg::OP_SPAD_RSP;
            c.crd_idx = 2'(wr[$urandom_range(0, wr.size() - 1)]);
        end
        add_item(c);
        return 1;
    endfunction

    function automatic void drain_all();
        while (add_response(1'($urandom_range(0, 1))));
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        rdlc_pkg::t_cmd c;
        int r;
        i_rst_n = 0;
        reset_shadow();
        // directed: idle op, zero-row issue, extremes, stray responses
        c = rand_cmd(); c.op = rdlc_pkg::OP_NONE; add_item(c);
        add_issue(8'd0, 0, 0, 0, 0, 0);
        c = rand_cmd(); c.op = rdlc_pkg::OP_DRAM_RSP; c.buf_idx = 3'd7; add_item(c);
        c = rand_cmd(); c.op = rdlc_pkg::OP_SPAD_RSP; c.crd_idx = 2'd3; add_item(c);
        add_issue(8'd255, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd3);
        drain_all();
        // reused id with zero rows: later write responses give no done
        add_issue(8'd9, 40'h10, 32'h40, 32'h100, 32'h8, 11'd2);
        add_issue(8'd9, 0, 0, 0, 0, 0);
        drain_all();
        // fill the queue, then drop an issue
        add_issue(8'd1, 40'h1000, 32'h20, 32'h0, 32'h4, 11'd20);
        for (int i = 0; i < rdlc_pkg::QUEUE_DEPTH; i++)
            add_issue(8'(2 + i), 40'({$urandom, $urandom}), $urandom, $urandom, $urandom,
                      11'd2);
        add_issue(8'd77, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  11'd2047);
        drain_all();
        // random: mostly well-formed traffic, some noise
        while (pending_items.size() < 210) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                c = rand_cmd();
                if (c.op == rdlc_pkg::OP_ISSUE) c.rows = 11'($urandom_range(0, 8));
                add_item(c);
            end else if (r < 40 && add_response(1)) begin
            end else if (r < 70 && add_response(0)) begin
            end else begin
                c = rand_cmd();
                c.op = rdlc_pkg::OP_ISSUE;
                c.cmd_id = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 15));
                r = $urandom_range(0, 19);
                c.rows = (r == 0) ? 11'd0 : (r < 17) ? 11'($urandom_range(1, 6))
                                                     : 11'($urandom_range(7, 12));
                add_item(c);
            end
        end
        drain_all();
        stim_done = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // sender: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= rdlc_pkg::OP_NONE;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_axis_tvalid <= 0;
            end else begin
                rdlc_pkg::t_cmd c;
                c = pending_items.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tuser  <= c.op;
                s_axis_tdata  <= {c.crd_idx, c.buf_idx, c.rows, c.dstride, c.dst,
                                  c.sstride, c.src, c.cmd_id};
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold
    int hold_left = 0, ready_mode = 0, mode_left = 0;
    bit hold_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else if (!hold_done && items_in >= 120) begin
            hold_done = 1;
            hold_left = 400;
            m_axis_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 40);
            end
            mode_left--;
            case (ready_mode)
                0: m_axis_tready <= 1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // monitor and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) items_in++;
            if (m_axis_tvalid && m_axis_tready) begin
                rdlc_pkg::t_result act, exp_r;
                act.kind = rdlc_pkg::t_kind'(m_axis_tuser);
                act.address = m_axis_tdata[39:0];
                act.buffer_slot = m_axis_tdata[42:40];
                act.credit_slot = m_axis_tdata[44:43];
                act.result_instr = m_axis_tdata[52:45];
                act.row_number = m_axis_tdata[63:53];
                act.queue_has_room = m_axis_tdata[64];
                act.issue_rejected = m_axis_tdata[65];
                act.last = m_axis_tlast;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, act);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (act !== exp_r || m_axis_tdata[71:66] !== 6'd0) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p fill %h", $time, exp_r,
                                 act, m_axis_tdata[71:66]);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000) begin
            $display("tb_row_dma_load_controller_unit: FAIL");
            $finish;
        end
    end

    initial begin
        wait (stim_done && i_rst_n);
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (30) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_row_dma_load_controller_unit: PASS");
        else
            $display("tb_row_dma_load_controller_unit: FAIL");
        $finish;
    end

endmodule

// ===== row_dma_load_controller_unit.f =====
rtl/rdlc_pkg.sv
rtl/rdlc_front.sv
rtl/rdlc_engine.sv
rtl/row_dma_load_controller_unit.sv
rtl/rdlc_checker.sv
verif/tb_row_dma_load_controller_unit.sv
